### rtl/core/pmk_pkg.sv
package pmk_pkg;

  localparam int COORD_BITS    = 32;
  localparam int BITS_PER_AXIS = 10;

  localparam int FIELD_W    = 32;
  localparam int BUCKET_W   = 10;
  localparam int KEY_W      = 30;
  localparam int NUM_AXES   = 3;
  localparam int NUM_REGS   = 6;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  // register indexes
  localparam int REG_MIN_X = 0;
  localparam int REG_MAX_X = 1;
  localparam int REG_MIN_Y = 2;
  localparam int REG_MAX_Y = 3;
  localparam int REG_MIN_Z = 4;
  localparam int REG_MAX_Z = 5;

  localparam logic [FIELD_W-1:0] RESET_MIN = 32'h0000_0000;
  localparam logic [FIELD_W-1:0] RESET_MAX = 32'h0001_0000;

  // start accept to the edge that takes the result
  localparam int PIPE_LATENCY = COORD_BITS + BITS_PER_AXIS + 4;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0]    morton_key;
    logic [BUCKET_W-1:0] bucket_x;
    logic [BUCKET_W-1:0] bucket_y;
    logic [BUCKET_W-1:0] bucket_z;
    logic                bad_box;
  } out_t;

  // low COORD_BITS bits of a field as two's complement, sign-extended by one bit
  function automatic logic signed [COORD_BITS:0] coord_ext(input logic [FIELD_W-1:0] raw);
    logic [2*FIELD_W-1:0]  wide;
    logic [COORD_BITS-1:0] c;
    wide = {{FIELD_W{1'b0}}, raw};
    c = wide[COORD_BITS-1:0];
    return {c[COORD_BITS-1], c};
  endfunction

  // x in bit 0, y in bit 1, z in bit 2
  function automatic logic [KEY_W-1:0] interleave3(input logic [BITS_PER_AXIS-1:0] bx,
                                                   input logic [BITS_PER_AXIS-1:0] by,
                                                   input logic [BITS_PER_AXIS-1:0] bz);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < BITS_PER_AXIS; i++) begin
      k[3*i]     = bx[i];
      k[3*i + 1] = by[i];
      k[3*i + 2] = bz[i];
    end
    return k;
  endfunction

endpackage

### rtl/core/point_to_morton_key.sv
// point_to_morton_key: 30-bit 3D Morton key of a Q16.16 point inside a box
//
// input channel: a point transaction is taken at a clock edge with start high
// and busy low; busy is low whenever rst_n is high, so a point can be given
// in every cycle.
// result channel: out_valid is high for one cycle with out_data; the
// receiver takes it at the edge that ends that cycle and cannot stall.
// throughput: one point per cycle. the pipeline holds per-axis dividers:
// one remainder bit per stage for the wrap (COORD_BITS stages) and one
// bucket bit per stage for the scaling (BITS_PER_AXIS stages).
// config: APB port, box registers at byte addresses 4*i, pready always high;
// write the box only while no point is in flight.
// reset: all points in flight are dropped, the box returns to [0, 1) on
// every axis; busy is high while rst_n is low.
module point_to_morton_key (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  pmk_pkg::in_t                        in_data,
  output logic                                out_valid,
  output pmk_pkg::out_t                       out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pmk_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CB = pmk_pkg::COORD_BITS;
  localparam int B  = pmk_pkg::BITS_PER_AXIS;
  localparam int NA = pmk_pkg::NUM_AXES;

  // configuration
  logic [pmk_pkg::FIELD_W-1:0]   cfg_r [pmk_pkg::NUM_REGS];
  logic [pmk_pkg::REG_IDX_W-1:0] cfg_idx;
  logic                          cfg_wr;

  // per-axis raw values
  logic [pmk_pkg::FIELD_W-1:0] lo_raw [NA];
  logic [pmk_pkg::FIELD_W-1:0] hi_raw [NA];
  logic [pmk_pkg::FIELD_W-1:0] p_raw  [NA];
  logic signed [CB:0]          ext_full [NA];

  logic [CB-1:0] ext_r   [NA];
  logic [CB-1:0] ext_nxt [NA];
  logic          bad_r, bad_nxt;

  // offset stage
  logic signed [CB:0] d_r   [NA];
  logic signed [CB:0] d_nxt [NA];
  logic               v1_r, v1_nxt;

  // wrap divider stages
  logic [CB-1:0] md_rem_r   [CB+1][NA];
  logic [CB-1:0] md_rem_nxt [CB+1][NA];
  logic [CB-1:0] md_dvd_r   [CB+1][NA];
  logic [CB-1:0] md_dvd_nxt [CB+1][NA];
  logic          md_neg_r   [CB+1][NA];
  logic          md_neg_nxt [CB+1][NA];
  logic          md_v_r     [CB+1];
  logic          md_v_nxt   [CB+1];

  // scaling divider stages
  logic [CB-1:0] sc_rem_r   [B+1][NA];
  logic [CB-1:0] sc_rem_nxt [B+1][NA];
  logic [B-1:0]  sc_q_r     [B+1][NA];
  logic [B-1:0]  sc_q_nxt   [B+1][NA];
  logic          sc_v_r     [B+1];
  logic          sc_v_nxt   [B+1];

  pmk_pkg::out_t out_data_r, out_data_nxt;
  logic          out_valid_r;

  assign busy       = ~rst_n;
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[pmk_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_idx < pmk_pkg::REG_IDX_W'(pmk_pkg::NUM_REGS));

  always_comb begin
    if (cfg_idx < pmk_pkg::REG_IDX_W'(pmk_pkg::NUM_REGS)) begin
      cfg_prdata = cfg_r[cfg_idx];
    end else begin
      cfg_prdata = '0;
    end
  end

  assign lo_raw[0] = cfg_r[pmk_pkg::REG_MIN_X];
  assign hi_raw[0] = cfg_r[pmk_pkg::REG_MAX_X];
  assign lo_raw[1] = cfg_r[pmk_pkg::REG_MIN_Y];
  assign hi_raw[1] = cfg_r[pmk_pkg::REG_MAX_Y];
  assign lo_raw[2] = cfg_r[pmk_pkg::REG_MIN_Z];
  assign hi_raw[2] = cfg_r[pmk_pkg::REG_MAX_Z];
  assign p_raw[0]  = in_data.pos_x;
  assign p_raw[1]  = in_data.pos_y;
  assign p_raw[2]  = in_data.pos_z;

  assign v1_nxt = start && !busy;

  // extent and offset, full precision so nothing wraps
  always_comb begin
    bad_nxt = 1'b0;
    for (int a = 0; a < NA; a++) begin
      ext_full[a] = pmk_pkg::coord_ext(hi_raw[a]) - pmk_pkg::coord_ext(lo_raw[a]);
      d_nxt[a]    = pmk_pkg::coord_ext(p_raw[a]) - pmk_pkg::coord_ext(lo_raw[a]);
      ext_nxt[a]  = ext_full[a][CB-1:0];
      if (ext_full[a][CB] || ext_full[a] == '0) begin
        bad_nxt = 1'b1;
      end
    end
  end

  // restoring division of |offset| by extent, one remainder bit per stage
  always_comb begin
    logic [CB:0] absd;
    logic [CB:0] trial;
    logic [CB:0] diff;
    md_v_nxt[0] = v1_r;
    for (int a = 0; a < NA; a++) begin
      md_neg_nxt[0][a] = d_r[a][CB];
      absd = d_r[a][CB] ? -d_r[a] : d_r[a];
      md_dvd_nxt[0][a] = absd[CB-1:0];
      md_rem_nxt[0][a] = '0;
    end
    for (int k = 0; k < CB; k++) begin
      md_v_nxt[k+1] = md_v_r[k];
      for (int a = 0; a < NA; a++) begin
        trial = {md_rem_r[k][a], md_dvd_r[k][a][CB-1]};
        diff  = trial - {1'b0, ext_r[a]};
        if (trial >= {1'b0, ext_r[a]}) begin
          md_rem_nxt[k+1][a] = diff[CB-1:0];
        end else begin
          md_rem_nxt[k+1][a] = trial[CB-1:0];
        end
        md_dvd_nxt[k+1][a] = md_dvd_r[k][a] << 1;
        md_neg_nxt[k+1][a] = md_neg_r[k][a];
      end
    end
  end

  // fold negative remainder up by one extent, then divide r*2^B by extent
  always_comb begin
    logic [CB:0] trial;
    logic [CB:0] diff;
    logic        ge;
    logic [B:0]  qext;
    sc_v_nxt[0] = md_v_r[CB];
    for (int a = 0; a < NA; a++) begin
      if (md_neg_r[CB][a] && md_rem_r[CB][a] != '0) begin
        sc_rem_nxt[0][a] = ext_r[a] - md_rem_r[CB][a];
      end else begin
        sc_rem_nxt[0][a] = md_rem_r[CB][a];
      end
      sc_q_nxt[0][a] = '0;
    end
    for (int k = 0; k < B; k++) begin
      sc_v_nxt[k+1] = sc_v_r[k];
      for (int a = 0; a < NA; a++) begin
        trial = {sc_rem_r[k][a], 1'b0};
        diff  = trial - {1'b0, ext_r[a]};
        ge    = (trial >= {1'b0, ext_r[a]});
        if (ge) begin
          sc_rem_nxt[k+1][a] = diff[CB-1:0];
        end else begin
          sc_rem_nxt[k+1][a] = trial[CB-1:0];
        end
        qext = {sc_q_r[k][a], ge};
        sc_q_nxt[k+1][a] = qext[B-1:0];
      end
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (bad_r) begin
      out_data_nxt.bad_box = 1'b1;
    end else begin
      out_data_nxt.bucket_x   = pmk_pkg::BUCKET_W'(sc_q_r[B][0]);
      out_data_nxt.bucket_y   = pmk_pkg::BUCKET_W'(sc_q_r[B][1]);
      out_data_nxt.bucket_z   = pmk_pkg::BUCKET_W'(sc_q_r[B][2]);
      out_data_nxt.morton_key = pmk_pkg::interleave3(sc_q_r[B][0], sc_q_r[B][1],
                                                     sc_q_r[B][2]);
    end
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= CB; k++) md_v_r[k] <= 1'b0;
      for (int k = 0; k <= B; k++) sc_v_r[k] <= 1'b0;
      cfg_r[pmk_pkg::REG_MIN_X] <= pmk_pkg::RESET_MIN;
      cfg_r[pmk_pkg::REG_MAX_X] <= pmk_pkg::RESET_MAX;
      cfg_r[pmk_pkg::REG_MIN_Y] <= pmk_pkg::RESET_MIN;
      cfg_r[pmk_pkg::REG_MAX_Y] <= pmk_pkg::RESET_MAX;
      cfg_r[pmk_pkg::REG_MIN_Z] <= pmk_pkg::RESET_MIN;
      cfg_r[pmk_pkg::REG_MAX_Z] <= pmk_pkg::RESET_MAX;
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= sc_v_r[B];
      for (int k = 0; k <= CB; k++) md_v_r[k] <= md_v_nxt[k];
      for (int k = 0; k <= B; k++) sc_v_r[k] <= sc_v_nxt[k];
      if (cfg_wr) begin
        cfg_r[cfg_idx] <= cfg_pwdata;
      end
    end
  end

  // datapath; extent tracks the box every cycle; user must hold the box steady in flight, block does not enforce it
  always_ff @(posedge clk) begin
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
    for (int a = 0; a < NA; a++) begin
      ext_r[a] <= ext_nxt[a];
      d_r[a]   <= d_nxt[a];
    end
    for (int k = 0; k <= CB; k++) begin
      for (int a = 0; a < NA; a++) begin
        md_rem_r[k][a] <= md_rem_nxt[k][a];
        md_dvd_r[k][a] <= md_dvd_nxt[k][a];
        md_neg_r[k][a] <= md_neg_nxt[k][a];
      end
    end
    for (int k = 0; k <= B; k++) begin
      for (int a = 0; a < NA; a++) begin
        sc_rem_r[k][a] <= sc_rem_nxt[k][a];
        sc_q_r[k][a]   <= sc_q_nxt[k][a];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/pmk_checker.sv
module pmk_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input pmk_pkg::out_t out_data,
  input logic          cfg_pready
);

  localparam int B = pmk_pkg::BITS_PER_AXIS;

  // every accepted transaction comes out a fixed number of cycles later
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(pmk_pkg::PIPE_LATENCY) out_valid)
    else $error("accepted transaction produced no result");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, pmk_pkg::PIPE_LATENCY))
    else $error("result without a matching transaction");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_box) |->
      (out_data.morton_key == '0 && out_data.bucket_x == '0 &&
       out_data.bucket_y == '0 && out_data.bucket_z == '0))
    else $error("degenerate box with nonzero key");

  a_key_interleave: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.bad_box) |->
      (out_data.morton_key == pmk_pkg::interleave3(out_data.bucket_x[B-1:0],
                                                   out_data.bucket_y[B-1:0],
                                                   out_data.bucket_z[B-1:0])))
    else $error("key does not match buckets");

  a_ready_out_of_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && cfg_pready))
    else $error("busy or not ready outside reset");

endmodule

bind point_to_morton_key pmk_checker u_pmk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);
